>>> sv/hotp_pkg.sv
// Shared types and constants for the one-time password checker.
package hotp_pkg;
	localparam int unsigned CodeModulusDefault = 1000000;
	localparam logic [15:0] TimeStepReset = 16'd30;
	localparam logic [31:0] IpadWord = 32'h36363636;
	localparam logic [31:0] OpadWord = 32'h5c5c5c5c;
	localparam logic [1:0] RegKey0 = 2'd0;
	localparam logic [1:0] RegKey1 = 2'd1;
	localparam logic [1:0] RegKey2 = 2'd2;
	localparam logic [1:0] RegStep = 2'd3;
	localparam logic OpCounter = 1'b0;
	localparam logic OpTime = 1'b1;

	typedef struct packed {
		logic start;
		logic [1:0] blk;
	} cmp_req_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] t);
		if (t < 7'd20) round_k = 32'h5A827999;
		else if (t < 7'd40) round_k = 32'h6ED9EBA1;
		else if (t < 7'd60) round_k = 32'h8F1BBCDC;
		else round_k = 32'hCA62C1D6;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		if (t < 7'd20) round_f = (b & c) | (~b & d);
		else if (t < 7'd40) round_f = b ^ c ^ d;
		else if (t < 7'd60) round_f = (b & c) | (b & d) | (c & d);
		else round_f = b ^ c ^ d;
	endfunction
endpackage

>>> sv/hotp_div.sv
// Restoring divider, one quotient bit per cycle.
module hotp_div #(
	parameter int NW = 64,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [NW-1:0] q_q;
	logic [DW:0] r_q;
	logic [DW-1:0] d_q;
	logic [DW:0] trial;
	logic [DW:0] shifted;

	assign shifted = {r_q[DW-1:0], q_q[NW-1]};
	assign trial = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!trial[DW]) begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= shifted;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
endmodule

>>> sv/hotp_sha1.sv
// SHA-1 compression with the schedule held in a synchronous-read memory.
module hotp_sha1 (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hotp_pkg::cmp_req_t    req,
	input  logic [159:0]          chain_in,
	input  logic                  ld_we,
	input  logic [3:0]            ld_addr,
	input  logic [31:0]           ld_data,
	output logic                  done,
	output logic [159:0]          chain_out
);
	logic [31:0] sched_mem [16];
	logic [31:0] rd0, rd1, rd2, rd3;
	logic [6:0] round_count_q;
	logic [1:0] ph_q;
	logic busy_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w;
	logic [3:0] t4;
	logic we;
	logic [3:0] wa;
	logic [31:0] wd;

	// Per round: phase 0 issues four reads, phase 1 register, phase 2 computes.
	assign t4 = round_count_q[3:0];
	assign w = (round_count_q < 7'd16) ? rd3 : hotp_pkg::rotl(rd0 ^ rd1 ^ rd2 ^ rd3, 1);

	always_comb begin
		we = ld_we;
		wa = ld_addr;
		wd = ld_data;
		if (busy_q && ph_q == 2'd2) begin
			we = round_count_q >= 7'd16;
			wa = t4;
			wd = w;
		end
	end

	always_ff @(posedge clk) begin
		if (we) sched_mem[wa] <= wd;
		rd0 <= sched_mem[t4 + 4'd13];
		rd1 <= sched_mem[t4 + 4'd8];
		rd2 <= sched_mem[t4 + 4'd2];
		rd3 <= sched_mem[t4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q <= '0;
			round_count_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				ph_q <= '0;
				round_count_q <= '0;
			end else if (busy_q) begin
				if (ph_q == 2'd2) begin
					ph_q <= '0;
					if (round_count_q == 7'd79) begin
						busy_q <= 1'b0;
						round_count_q <= '0;
						done <= 1'b1;
					end else begin
						round_count_q <= round_count_q + 1'b1;
					end
				end else begin
					ph_q <= ph_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			{a_q, b_q, c_q, d_q, e_q} <= chain_in;
		end else if (busy_q && ph_q == 2'd2) begin
			a_q <= hotp_pkg::rotl(a_q, 5) + hotp_pkg::round_f(round_count_q, b_q, c_q, d_q)
				+ e_q + hotp_pkg::round_k(round_count_q) + w;
			b_q <= a_q;
			c_q <= hotp_pkg::rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign chain_out = {chain_in[159:128] + a_q, chain_in[127:96] + b_q,
		chain_in[95:64] + c_q, chain_in[63:32] + d_q, chain_in[31:0] + e_q};
endmodule

>>> sv/hmac_sha1_otp_validator_top.sv
// Top level of the HMAC-SHA1 six-digit one-time password checker.
//  channel | dir | beat contents
//  s_axis  | in  | tdata: moving_value[63:0], candidate_code[83:64]; tuser: opcode
//  m_axis  | out | tdata: computed_code[19:0], code_matches[20]
//  cfg     | in  | cfg_index selects register, cfg_data value
// A counter item runs four compressions, then truncation and reciprocal reduction; a time
// item first runs the bit-serial time-step divide. Each compression loads the 16 schedule
// words, starts, runs 80 rounds that each wait on the registered memory read, and ends
// when the controller sees done.
// Items are taken one at a time; the next beat is taken once the controller is idle. A
// stalled result holds in the output register and stalls only the next result.
// Reset clears the controller; schedule and chain contents are rewritten per item.
module hmac_sha1_otp_validator_top #(
	parameter int unsigned CODE_MODULUS = hotp_pkg::CodeModulusDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,  // moving_value, candidate_code
	input  logic        s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // computed_code, code_matches
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	localparam longint unsigned RECIP_W =
		((64'd1 << 32) + 64'(CODE_MODULUS) - 64'd1) / 64'(CODE_MODULUS);
	localparam logic [31:0] RECIP = 32'(RECIP_W);
	localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_LOAD = 4'd2, S_CMP = 4'd3,
		S_NEXT = 4'd4, S_TRUNC = 4'd5, S_MOD = 4'd6, S_OUT = 4'd7, S_RED = 4'd8;

	logic [63:0] key0_q, key1_q;
	logic [31:0] key2_q;
	logic [15:0] step_q;
	logic [3:0] st_q;
	logic [1:0] blk_q;
	logic [4:0] li_q;
	logic [63:0] factor_q;
	logic [19:0] cand_q;
	logic [159:0] chain_q, inner_q;
	logic [31:0] bin_q;
	logic [31:0] qe_q;
	logic [32:0] diff_q;
	logic [20:0] out_q;
	logic [63:0] rprod, qmul;
	logic [31:0] code_full;
	logic out_ld;
	hotp_pkg::cmp_req_t req;
	logic ld_we;
	logic [31:0] ld_data;
	logic cmp_done;
	logic [159:0] cmp_out;
	logic div_start, div_done;
	logic [63:0] div_num, div_quo;
	logic [31:0] div_den;
	logic [31:0] pad;
	logic [159:0] iv;
	logic [7:0] mb [20];
	logic [3:0] off;

	assign iv = 160'h67452301EFCDAB8998BADCFE10325476C3D2E1F0;
	assign cfg_ready = 1'b1;
	assign s_axis_tready = (st_q == S_IDLE);
	assign pad = blk_q[1] ? hotp_pkg::OpadWord : hotp_pkg::IpadWord;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
			step_q <= hotp_pkg::TimeStepReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				hotp_pkg::RegKey0: key0_q <= cfg_data;
				hotp_pkg::RegKey1: key1_q <= cfg_data;
				hotp_pkg::RegKey2: key2_q <= cfg_data[31:0];
				hotp_pkg::RegStep: step_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ld_data = '0;
		if (!blk_q[0]) begin
			case (li_q[3:0])
				4'd0: ld_data = key0_q[63:32] ^ pad;
				4'd1: ld_data = key0_q[31:0] ^ pad;
				4'd2: ld_data = key1_q[63:32] ^ pad;
				4'd3: ld_data = key1_q[31:0] ^ pad;
				4'd4: ld_data = key2_q ^ pad;
				default: ld_data = pad;
			endcase
		end else if (!blk_q[1]) begin
			case (li_q[3:0])
				4'd0: ld_data = factor_q[63:32];
				4'd1: ld_data = factor_q[31:0];
				4'd2: ld_data = 32'h80000000;
				4'd15: ld_data = 32'd576;
				default: ld_data = '0;
			endcase
		end else begin
			case (li_q[3:0])
				4'd0: ld_data = inner_q[159:128];
				4'd1: ld_data = inner_q[127:96];
				4'd2: ld_data = inner_q[95:64];
				4'd3: ld_data = inner_q[63:32];
				4'd4: ld_data = inner_q[31:0];
				4'd5: ld_data = 32'h80000000;
				4'd15: ld_data = 32'd672;
				default: ld_data = '0;
			endcase
		end
	end

	assign ld_we = (st_q == S_LOAD);
	assign req.start = (st_q == S_CMP);
	assign req.blk = blk_q;

	hotp_sha1 u_sha1 (
		.clk(clk), .arst_n(arst_n), .req(req), .chain_in(chain_q),
		.ld_we(ld_we), .ld_addr(li_q[3:0]), .ld_data(ld_data),
		.done(cmp_done), .chain_out(cmp_out)
	);

	always_comb begin
		for (int i = 0; i < 20; i++) mb[i] = chain_q[159 - 8*i -: 8];
	end
	assign off = mb[19][3:0];

	assign div_start = s_axis_tvalid && s_axis_tready && s_axis_tuser == hotp_pkg::OpTime;
	assign div_num = s_axis_tdata[63:0];
	assign div_den = (step_q == '0) ? 32'd1 : {16'd0, step_q};

	hotp_div #(.NW(64), .DW(32)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	// quotient estimate from the reciprocal is exact or one too high
	assign rprod = 64'(bin_q) * 64'(RECIP);
	assign qmul = 64'(qe_q) * 64'(CODE_MODULUS);
	assign code_full = diff_q[32] ? diff_q[31:0] + 32'(CODE_MODULUS) : diff_q[31:0];
	assign out_ld = (st_q == S_OUT) && (!m_axis_tvalid || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			m_axis_tvalid <= 1'b0;
			blk_q <= '0;
			li_q <= '0;
		end else begin
			if (out_ld) m_axis_tvalid <= 1'b1;
			else if (m_axis_tready) m_axis_tvalid <= 1'b0;
			case (st_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					blk_q <= '0;
					li_q <= '0;
					st_q <= (s_axis_tuser == hotp_pkg::OpTime) ? S_DIV : S_LOAD;
				end
				S_DIV: if (div_done) st_q <= S_LOAD;
				S_LOAD: begin
					li_q <= li_q + 1'b1;
					if (li_q == 5'd15) st_q <= S_CMP;
				end
				S_CMP: st_q <= S_NEXT;
				S_NEXT: if (cmp_done) begin
					li_q <= '0;
					blk_q <= blk_q + 1'b1;
					st_q <= (blk_q == 2'd3) ? S_TRUNC : S_LOAD;
				end
				S_TRUNC: st_q <= S_MOD;
				S_MOD: st_q <= S_RED;
				S_RED: st_q <= S_OUT;
				S_OUT: if (out_ld) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			factor_q <= s_axis_tdata[63:0];
			cand_q <= s_axis_tdata[83:64];
		end
		if (st_q == S_DIV && div_done) factor_q <= div_quo;
		if (st_q == S_LOAD && li_q == 5'd0 && !blk_q[0]) chain_q <= iv;
		if (st_q == S_NEXT && cmp_done) begin
			chain_q <= cmp_out;
			if (blk_q == 2'd1) inner_q <= cmp_out;
		end
		if (st_q == S_TRUNC) bin_q <= {1'b0, mb[off][6:0], mb[5'(off) + 5'd1],
			mb[5'(off) + 5'd2], mb[5'(off) + 5'd3]};
		if (st_q == S_MOD) qe_q <= rprod[63:32];
		if (st_q == S_RED) diff_q <= {1'b0, bin_q} - qmul[32:0];
		if (out_ld) out_q <= {(code_full == {12'd0, cand_q}), code_full[19:0]};
	end

	assign m_axis_tdata = {3'd0, out_q};

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(st_q) == S_OUT) else $error("stray result");
	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_LOAD) |-> !li_q[4]) else $error("load index overrun");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result beat changed while stalled");
`endif
endmodule
